@@ sv/gcdisp_pkg.sv @@
// Shared types and constants of the guided chunk dispatcher.
package gcdisp_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned PCOUNT_W = 7;
	localparam int unsigned PIDX_W   = 6;
	// cursor never exceeds count + span, so one bit above a word is enough
	localparam int unsigned CURSOR_W = WORD_W + 1;

	localparam logic OP_START = 1'b0;
	localparam logic OP_CLAIM = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic              op;
		logic [PIDX_W-1:0] participant;
		word_t             job_count;
		word_t             job_grain;
	} in_item_t;

	typedef struct packed {
		word_t range_begin;
		word_t range_end;
		logic  exhausted;
		logic  bad_participant;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV1,
		ST_DIV2
	} state_t;

	typedef struct packed {
		logic capture;
		logic job_load;
		logic claim_emit;
		logic claim_commit;
		logic grain_store;
		logic div_share;
		logic div_grain;
		logic span_store;
	} cmd_t;

	typedef struct packed {
		logic is_start;
		logic bad;
		logic exhausted;
		logic need_div;
		logic out_blocked;
		logic div_done;
	} sts_t;

endpackage

@@ sv/gcdisp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module gcdisp_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/gcdisp_div.sv @@
// Restoring divider, one quotient bit per cycle.
module gcdisp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  gcdisp_pkg::word_t  dividend,
	input  gcdisp_pkg::word_t  divisor,
	output logic               done,
	output gcdisp_pkg::word_t  quotient,
	output gcdisp_pkg::word_t  remainder
);
	import gcdisp_pkg::*;

	localparam int unsigned STEP_W = $clog2(WORD_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	word_t             quo_q;
	word_t             rem_q;
	word_t             dvs_q;

	logic [WORD_W:0]   trial;
	logic [WORD_W:0]   diff;
	logic              fits;
	word_t             rem_nxt;

	always_comb begin
		trial   = {rem_q, quo_q[WORD_W-1]};
		diff    = trial - {1'b0, dvs_q};
		fits    = trial >= {1'b0, dvs_q};
		rem_nxt = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(WORD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[WORD_W-2:0], fits};
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

@@ sv/gcdisp_ctrl.sv @@
// Sequencer: accepts items and steps the datapath through claim and span work.
module gcdisp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  gcdisp_pkg::sts_t  sts,
	output gcdisp_pkg::cmd_t  cmd
);
	import gcdisp_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_stall  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (sts.is_start) begin
					cmd.job_load  = 1'b1;
					cmd.div_share = 1'b1;
					state_nxt     = ST_DIV1;
				end else if (!sts.out_blocked) begin
					cmd.claim_emit = 1'b1;
					state_nxt      = ST_IDLE;
					if (!sts.bad && !sts.exhausted) begin
						cmd.claim_commit = 1'b1;
						if (sts.need_div) begin
							cmd.div_share = 1'b1;
							state_nxt     = ST_DIV1;
						end else begin
							cmd.grain_store = 1'b1;
						end
					end
				end
			end
			ST_DIV1: begin
				if (sts.div_done) begin
					cmd.div_grain = 1'b1;
					state_nxt     = ST_DIV2;
				end
			end
			ST_DIV2: begin
				if (sts.div_done) begin
					cmd.span_store = 1'b1;
					state_nxt      = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

@@ sv/gcdisp_dpath.sv @@
// Datapath: job state, per-participant spans, divider and result register.
module gcdisp_dpath #(
	parameter int unsigned MAX_PARTICIPANTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gcdisp_pkg::in_item_t                in_data,
	input  logic                                cfg_wr_en,
	input  logic [gcdisp_pkg::PCOUNT_W-1:0]     cfg_wr_data,
	input  gcdisp_pkg::cmd_t                    cmd,
	output gcdisp_pkg::sts_t                    sts,
	output logic                                out_valid,
	input  logic                                out_stall,
	output gcdisp_pkg::out_item_t               out_data
);
	import gcdisp_pkg::*;

	localparam int unsigned AW = (MAX_PARTICIPANTS > 1) ? $clog2(MAX_PARTICIPANTS) : 1;

	logic [PCOUNT_W-1:0]         pcount_q;
	in_item_t                    item_q;
	logic [CURSOR_W-1:0]         cursor_q;
	word_t                       count_q;
	word_t                       grain_q;
	word_t                       first_span_q;
	logic [MAX_PARTICIPANTS-1:0] fresh_q;
	word_t                       q1_q;
	logic                        out_valid_q;
	out_item_t                   out_q;

	logic [AW-1:0]       pidx;
	logic                bad;
	logic                exhausted;
	word_t               span;
	word_t               claimed;
	logic [WORD_W:0]     after;
	word_t               left_count;
	word_t               limit;
	logic                need_div;
	word_t               rem_left;
	word_t               grain_nz;
	word_t               grain_cl;
	word_t               grain_new;
	logic [PCOUNT_W-1:0] pc_eff;
	word_t               div_a;
	word_t               div_b;
	logic                div_start;
	logic                div_done;
	word_t               div_quo;
	word_t               div_rem;
	word_t               span_new;
	logic                ram_we;
	logic [AW-1:0]       ram_raddr;
	word_t               ram_wdata;
	word_t               ram_rdata;
	out_item_t           result;

	always_comb begin
		pidx       = AW'(item_q.participant);
		bad        = ({1'b0, item_q.participant} >= pcount_q)
		          || (32'(item_q.participant) >= 32'(MAX_PARTICIPANTS));
		exhausted  = cursor_q >= {1'b0, count_q};
		span       = fresh_q[pidx] ? first_span_q : ram_rdata;
		claimed    = cursor_q[WORD_W-1:0];
		after      = {1'b0, claimed} + {1'b0, span};
		left_count = count_q - claimed;
		limit      = (left_count < span) ? count_q : after[WORD_W-1:0];
		need_div   = after < {1'b0, count_q};
		rem_left   = count_q - after[WORD_W-1:0];

		// grain: zero means one, then at most the count, and never zero
		grain_nz  = (item_q.job_grain == '0) ? WORD_W'(1) : item_q.job_grain;
		grain_cl  = (grain_nz > item_q.job_count) ? item_q.job_count : grain_nz;
		grain_new = (grain_cl == '0) ? WORD_W'(1) : grain_cl;

		pc_eff = (pcount_q == '0) ? PCOUNT_W'(1) : pcount_q;

		div_start = cmd.div_share || cmd.div_grain;
		if (cmd.div_grain) begin
			div_a = div_quo;
			div_b = grain_q;
		end else begin
			div_a = (item_q.op == OP_START) ? item_q.job_count : rem_left;
			div_b = WORD_W'({pc_eff, 1'b0});
		end

		// batch * grain is the share minus its remainder by grain
		span_new = (q1_q >= grain_q) ? (q1_q - div_rem) : grain_q;

		// read the incoming index on capture, then keep reading the held one
		ram_raddr = cmd.capture ? AW'(in_data.participant) : pidx;
		ram_we    = cmd.grain_store || (cmd.span_store && (item_q.op == OP_CLAIM));
		ram_wdata = cmd.grain_store ? grain_q : span_new;

		result = '0;
		if (bad) begin
			result.bad_participant = 1'b1;
		end else if (exhausted) begin
			result.exhausted = 1'b1;
		end else begin
			result.range_begin = claimed;
			result.range_end   = limit;
		end

		sts.is_start    = item_q.op == OP_START;
		sts.bad         = bad;
		sts.exhausted   = exhausted;
		sts.need_div    = need_div;
		sts.out_blocked = out_valid_q && out_stall;
		sts.div_done    = div_done;
	end

	gcdisp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	gcdisp_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_PARTICIPANTS),
		.AW    (AW)
	) u_span_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pidx),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q     <= PCOUNT_W'(1);
			cursor_q     <= '0;
			count_q      <= '0;
			grain_q      <= WORD_W'(1);
			first_span_q <= '0;
			fresh_q      <= '1;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				pcount_q <= cfg_wr_data;
			end
			if (cmd.job_load) begin
				count_q  <= item_q.job_count;
				grain_q  <= grain_new;
				cursor_q <= '0;
				fresh_q  <= '1;
			end
			if (cmd.claim_commit) begin
				cursor_q      <= after;
				fresh_q[pidx] <= 1'b0;
			end
			if (cmd.span_store && (item_q.op == OP_START)) begin
				first_span_q <= span_new;
			end
			if (cmd.claim_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
		if (cmd.div_grain) begin
			q1_q <= div_quo;
		end
		if (cmd.claim_emit) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ sv/guided_chunk_dispatcher_core.sv @@
// Top level of the guided chunk dispatcher: sequencer plus datapath.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data): op START loads job_count and
//    job_grain (grain clamped to 1..count, 1 for count 0), rewinds the cursor
//    and marks every participant fresh; it produces no result. op CLAIM asks for
//    the next range of one participant and always produces exactly one result.
//  - Output channel (out_valid / out_stall / out_data): [range_begin, range_end),
//    or exhausted once the job is used up, or bad_participant for an index not
//    below participant_count or MAX_PARTICIPANTS (nothing changes then).
//  - cfg_wr_en / cfg_wr_data write participant_count; write only while idle.
//  - Timing: a claim result is registered once the output register is free.
//    Claims that are bad, exhausted or take the last range free the input as
//    their result is registered. A claim that needs a new span, and every start,
//    runs two divisions on the shared bit-serial divider before the next item
//    is accepted.
//  - A stalled result sits in the output register; the block keeps working and
//    only holds a new claim's result until that register frees up.
//  - Reset: participant_count 1, empty job (every claim is exhausted), all
//    participants fresh. Span storage needs no clearing after reset.
module guided_chunk_dispatcher_core #(
	parameter int unsigned MAX_PARTICIPANTS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  gcdisp_pkg::in_item_t            in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output gcdisp_pkg::out_item_t           out_data,
	input  logic                            cfg_wr_en,
	input  logic [gcdisp_pkg::PCOUNT_W-1:0] cfg_wr_data
);
	import gcdisp_pkg::*;

	cmd_t cmd;   // sequencer -> datapath
	sts_t sts;   // datapath -> sequencer

	// sequencer: one item at a time; stall is low only in the idle state
	gcdisp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: cursor, job registers, fresh flags, span RAM, divider, output reg
	gcdisp_dpath #(
		.MAX_PARTICIPANTS (MAX_PARTICIPANTS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

@@ sv/gcdisp_checker.sv @@
// Port-level checks for the guided chunk dispatcher, bound to the top level.
module gcdisp_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input gcdisp_pkg::out_item_t out_data
);
	import gcdisp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled result changed");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a transfer");

	a_result_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

	a_range_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.exhausted && !out_data.bad_participant
		|-> out_data.range_begin < out_data.range_end)
		else $error("granted range is empty");

endmodule

bind guided_chunk_dispatcher_core gcdisp_checker u_gcdisp_checker (.*);

@@ tb/tb_guided_chunk_dispatcher_core.sv @@
// Self-checking testbench for guided_chunk_dispatcher_core: random jobs and claims vs. a predictor.
`timescale 1ns / 100ps

module tb_guided_chunk_dispatcher_core;
	import gcdisp_pkg::*;

	localparam int unsigned NPART       = 64;
	localparam int unsigned DRAIN_CYC   = 80;    // start runs two serial divides
	localparam int unsigned TAIL_CYC    = 100;
	localparam int unsigned QUIET_LIMIT = 4000;  // cycles without any transfer
	localparam int unsigned HOLD_CYC    = 400;   // long receiver hold-off
	localparam int unsigned HOLD_AT     = 700;   // input transfers before the hold-off

	// ---------------------------------------------------------------------
	// Clock, reset and block inputs (all known from time zero)
	// ---------------------------------------------------------------------
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	in_item_t            in_data   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_item_t           out_data;
	logic                cfg_wr_en   = 1'b0;
	logic [PCOUNT_W-1:0] cfg_wr_data = '0;

	always #5 clk = ~clk;

	guided_chunk_dispatcher_core #(
		.MAX_PARTICIPANTS(NPART)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// ---------------------------------------------------------------------
	// Predictor state: mirrors the dispatcher's job and per-participant spans
	// ---------------------------------------------------------------------
	logic [PCOUNT_W-1:0] n_participants = 7'd1;
	longint unsigned     cursor         = 0;
	word_t               cur_count      = '0;
	word_t               cur_grain      = 32'd1;
	word_t               first_span     = '0;
	word_t               next_span [NPART];
	logic [NPART-1:0]    fresh          = '1;

	in_item_t  pending_items[$];    // filled by the stimulus, drained by the driver
	out_item_t expected_ranges[$];  // one per accepted claim

	int unsigned n_queued = 0, n_accepted = 0, n_starts = 0, n_claims = 0;
	int unsigned n_ranges = 0, n_exhausted = 0, n_bad = 0, n_results = 0, n_err = 0;
	bit          calm = 1'b0;       // phase with no idling on either side

	// Guided share: remainder / (2 * participants) rounded down to whole grains,
	// never below one grain. A participant count of zero divides as one.
	function automatic word_t guided_span(word_t left);
		longint unsigned divisor, g, batch;
		divisor = (n_participants == 0) ? 2 : 2 * longint'(n_participants);
		g       = (cur_grain == 0) ? 1 : cur_grain;
		batch   = (longint'(left) / divisor) / g;
		return (batch != 0) ? word_t'(batch * g) : word_t'(g);
	endfunction

	// Update the mirror for one accepted transfer; queue the result of a claim.
	function automatic void predict_range(in_item_t it);
		out_item_t       r;
		word_t           g, span;
		longint unsigned after;
		if (it.op == OP_START) begin
			g = (it.job_grain == 0) ? 32'd1 : it.job_grain;
			if (g > it.job_count)
				g = it.job_count;
			if (g == 0)
				g = 32'd1;
			cur_count  = it.job_count;
			cur_grain  = g;
			cursor     = 0;
			first_span = guided_span(it.job_count);  // uses participant count of this moment
			fresh      = '1;
			return;
		end
		r = '0;
		if (it.participant >= n_participants) begin
			r.bad_participant = 1'b1;                  // nothing changes
		end else if (cursor >= cur_count) begin
			r.exhausted = 1'b1;                        // cursor and spans stay put
		end else begin
			span                    = fresh[it.participant] ? first_span : next_span[it.participant];
			fresh[it.participant]   = 1'b0;
			after                   = cursor + span;
			r.range_begin           = cursor[31:0];
			r.range_end             = (cur_count - cursor < span) ? cur_count : after[31:0];
			cursor                  = after;
			next_span[it.participant] = (after >= cur_count) ? cur_grain
				: guided_span(word_t'(cur_count - after));
		end
		expected_ranges.push_back(r);
	endfunction

	// ---------------------------------------------------------------------
	// Driver: offers queued items, with a random gap after each
	// ---------------------------------------------------------------------
	int unsigned in_gap = 0;
	bit          in_xfer;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap   <= 0;
		end else begin
			in_xfer = in_valid && !in_stall;
			if (in_xfer) begin
				predict_range(in_data);
				n_accepted++;
				if (in_data.op == OP_START)
					n_starts++;
				else
					n_claims++;
			end
			// payload only moves once the current transfer is done
			if (!in_valid || in_xfer) begin
				if (in_gap != 0) begin
					in_valid <= 1'b0;
					in_gap   <= in_gap - 1;
				end else if (pending_items.size() != 0) begin
					in_data  <= pending_items.pop_front();
					in_valid <= 1'b1;
					in_gap   <= calm ? 0 : $urandom_range(0, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Long hold-off on the result side, counted here; the sender keeps going
	// so the block fills up and pushes back on its input.
	// ---------------------------------------------------------------------
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_accepted >= HOLD_AT) begin
			hold_left <= HOLD_CYC;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: checks each result against the oldest expectation, then
	// may stall at random before the next one
	// ---------------------------------------------------------------------
	int unsigned out_wait = 0;
	int unsigned out_draw;
	bit          out_xfer;
	out_item_t   want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_wait  <= 0;
		end else begin
			out_xfer = out_valid && !out_stall;
			if (out_xfer) begin
				n_results++;
				if (out_data.bad_participant)
					n_bad++;
				else if (out_data.exhausted)
					n_exhausted++;
				else
					n_ranges++;
				if (expected_ranges.size() == 0) begin
					$error("unexpected result: begin %0d end %0d exh %0b bad %0b",
						out_data.range_begin, out_data.range_end,
						out_data.exhausted, out_data.bad_participant);
					n_err++;
				end else begin
					want = expected_ranges.pop_front();
					if (out_data.range_begin !== want.range_begin) begin
						$error("range_begin: expected %0d, got %0d",
							want.range_begin, out_data.range_begin);
						n_err++;
					end
					if (out_data.range_end !== want.range_end) begin
						$error("range_end: expected %0d, got %0d",
							want.range_end, out_data.range_end);
						n_err++;
					end
					if (out_data.exhausted !== want.exhausted) begin
						$error("exhausted: expected %0b, got %0b",
							want.exhausted, out_data.exhausted);
						n_err++;
					end
					if (out_data.bad_participant !== want.bad_participant) begin
						$error("bad_participant: expected %0b, got %0b",
							want.bad_participant, out_data.bad_participant);
						n_err++;
					end
				end
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
			end else if (out_xfer) begin
				out_draw   = calm ? 0 : $urandom_range(0, 3);
				out_stall <= (out_draw != 0);
				out_wait  <= (out_draw != 0) ? out_draw - 1 : 0;
			end else if (out_wait != 0) begin
				out_stall <= 1'b1;
				out_wait  <= out_wait - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Watchdog: no transfer of any kind for too long ends the run
	// ---------------------------------------------------------------------
	int unsigned quiet = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("tb_guided_chunk_dispatcher_core: FAIL");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	task automatic push_start(word_t cnt, word_t grn);
		in_item_t it;
		it.op          = OP_START;
		it.participant = PIDX_W'($urandom_range(0, 63));  // unused on start
		it.job_count   = cnt;
		it.job_grain   = grn;
		pending_items.push_back(it);
		n_queued++;
	endtask

	task automatic push_claim(logic [PIDX_W-1:0] p);
		in_item_t it;
		it.op          = OP_CLAIM;
		it.participant = p;
		it.job_count   = $urandom;               // unused on claim
		it.job_grain   = $urandom;
		pending_items.push_back(it);
		n_queued++;
	endtask

	// Mostly in-range indices; about one in ten anywhere in the 6-bit space.
	function automatic logic [PIDX_W-1:0] pick_participant();
		int unsigned top;
		top = (n_participants > NPART) ? NPART : n_participants;
		if (top == 0 || $urandom_range(0, 9) == 0)
			return PIDX_W'($urandom_range(0, 63));
		return PIDX_W'($urandom_range(0, top - 1));
	endfunction

	// Register writes only with the block idle: everything sent, every result
	// in, and a pause covering a start's trailing divide.
	task automatic set_participants(logic [PCOUNT_W-1:0] v);
		while (pending_items.size() != 0 || in_valid || expected_ranges.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		n_participants = v;
	endtask

	// One job: a start with a mixed count/grain, then a run of claims.
	task automatic random_job(int unsigned claims);
		word_t cnt, grn;
		case ($urandom_range(0, 9))
			0:       cnt = '0;
			1, 2, 3: cnt = $urandom_range(1, 300);
			4, 5, 6: cnt = $urandom_range(300, 200000);
			default: cnt = $urandom;
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: grn = $urandom_range(0, 4);
			5, 6, 7:       grn = $urandom_range(0, 64);
			8:             grn = $urandom;
			default:       grn = cnt;
		endcase
		push_start(cnt, grn);
		repeat (claims) push_claim(pick_participant());
	endtask

	logic [PCOUNT_W-1:0] phase_count [7] = '{7'd1, 7'd64, 7'd3, 7'd127, 7'd0, 7'd8, 7'd2};
	int unsigned         phase_items [7] = '{200, 200, 200, 200, 40, 200, 200};

	initial begin
		int unsigned stop_at;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty job after reset, out-of-range index
		push_claim(6'd0);
		push_claim(6'd5);
		set_participants(7'd4);
		// count zero keeps grain one; claim 0 is exhausted, index 4 is bad
		push_start(32'd0, 32'd0);
		push_claim(6'd0);
		push_claim(6'd4);
		// small job claimed in turn by four participants
		push_start(32'd100, 32'd0);
		for (int i = 0; i < 8; i++)
			push_claim(6'(i % 4));
		// full-scale count with grain equal to it: one range takes everything
		push_start(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_claim(6'd0);
		push_claim(6'd1);
		push_start(32'd1000, 32'd7);
		push_claim(6'd3);
		push_claim(6'd2);
		// register change mid-job: first span stays, later spans follow
		set_participants(7'd64);
		push_claim(6'd3);
		push_claim(6'd63);
		// zero participants: every claim is a bad index
		set_participants(7'd0);
		push_claim(6'd0);
		// beyond the participant limit; grain above count
		set_participants(7'd127);
		push_start(32'd5, 32'd9);
		push_claim(6'd63);
		push_claim(6'd0);

		// Random phases, each at its own participant count
		for (int ph = 0; ph < 7; ph++) begin
			set_participants(phase_count[ph]);
			calm    = (phase_count[ph] == 7'd8);
			stop_at = n_queued + phase_items[ph];
			while (n_queued < stop_at) begin
				if ($urandom_range(0, 15) == 0)
					push_claim(PIDX_W'($urandom_range(0, 63)));  // stray claim against old job
				else
					random_job($urandom_range(4, 50));
			end
		end

		// drain, then a margin for anything still in flight
		while (pending_items.size() != 0 || in_valid || expected_ranges.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);

		$display("run: %0d transfers in (%0d starts, %0d claims), participant counts 0..127",
			n_accepted, n_starts, n_claims);
		$display("results: %0d ranges, %0d exhausted, %0d bad index, %0d mismatches",
			n_ranges, n_exhausted, n_bad, n_err);
		if (n_err == 0)
			$display("tb_guided_chunk_dispatcher_core: PASS");
		else
			$display("tb_guided_chunk_dispatcher_core: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/gcdisp_pkg.sv
sv/gcdisp_ram.sv
sv/gcdisp_div.sv
sv/gcdisp_ctrl.sv
sv/gcdisp_dpath.sv
sv/guided_chunk_dispatcher_core.sv
sv/gcdisp_checker.sv
tb/tb_guided_chunk_dispatcher_core.sv
